/* rtl/core/heu_pkg.sv */
package heu_pkg;

  localparam int unsigned HOLD_DEPTH = 5;
  localparam int unsigned OUT_DEPTH  = 6;

  localparam logic [7:0] CHAR_AMP   = 8'h26;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_SEMI  = 8'h3b;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // named escapes: lt, gt, quot, amp
  localparam int unsigned NAMED_NUM = 4;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_NAMED   = 4'd1,
    PH_NUMERIC = 4'd2
  } heu_phase_e;

  // decisions for one request, from decode to the state and result registers
  typedef struct packed {
    logic [2:0]  out_cnt;
    logic        dec_en;
    logic [7:0]  dec_val;
    logic        wr_en;
    logic [2:0]  wr_idx;
    logic [2:0]  cnt_d;
    heu_phase_e  phase_d;
    logic [9:0]  code_d;
  } heu_dec_t;

  // byte i of named escape k, zero past its end
  function automatic logic [7:0] pat_byte(input logic [1:0] k, input logic [2:0] i);
    logic [7:0] b;
    b = 8'h00;
    unique case (k)
      2'd0: begin
        unique case (i)
          3'd0: b = CHAR_AMP;
          3'd1: b = 8'h6c;
          3'd2: b = 8'h74;
          3'd3: b = CHAR_SEMI;
          default: b = 8'h00;
        endcase
      end
      2'd1: begin
        unique case (i)
          3'd0: b = CHAR_AMP;
          3'd1: b = 8'h67;
          3'd2: b = 8'h74;
          3'd3: b = CHAR_SEMI;
          default: b = 8'h00;
        endcase
      end
      2'd2: begin
        unique case (i)
          3'd0: b = CHAR_AMP;
          3'd1: b = 8'h71;
          3'd2: b = 8'h75;
          3'd3: b = 8'h6f;
          3'd4: b = 8'h74;
          3'd5: b = CHAR_SEMI;
          default: b = 8'h00;
        endcase
      end
      default: begin
        unique case (i)
          3'd0: b = CHAR_AMP;
          3'd1: b = 8'h61;
          3'd2: b = 8'h6d;
          3'd3: b = 8'h70;
          3'd4: b = CHAR_SEMI;
          default: b = 8'h00;
        endcase
      end
    endcase
    return b;
  endfunction

  function automatic logic [2:0] pat_len(input logic [1:0] k);
    logic [2:0] l;
    unique case (k)
      2'd0:    l = 3'd4;
      2'd1:    l = 3'd4;
      2'd2:    l = 3'd6;
      default: l = 3'd5;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] pat_val(input logic [1:0] k);
    logic [7:0] v;
    unique case (k)
      2'd0:    v = 8'h3c;
      2'd1:    v = 8'h3e;
      2'd2:    v = 8'h22;
      default: v = 8'h26;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/heu_decode.sv */
module heu_decode (
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  input  heu_pkg::heu_phase_e phase_i,
  input  logic [2:0]          cnt_i,
  input  logic [9:0]          code_i,
  input  logic [4:0][7:0]     held_i,
  output heu_pkg::heu_dec_t   dec_o
);

  logic       is_amp;
  logic       is_digit;
  logic       partial;
  logic       complete;
  logic       to_numeric;
  logic [7:0] val;
  logic [3:0] digit;
  logic       pm;

  assign is_amp   = (byte_i == heu_pkg::CHAR_AMP);
  assign is_digit = (byte_i >= heu_pkg::CHAR_ZERO) && (byte_i <= heu_pkg::CHAR_NINE);
  assign digit    = byte_i[3:0];

  // classify held bytes plus the new byte
  always_comb begin
    partial    = 1'b0;
    complete   = 1'b0;
    to_numeric = 1'b0;
    val        = 8'h00;
    pm         = 1'b0;
    if (phase_i == heu_pkg::PH_NAMED) begin
      for (int k = 0; k < heu_pkg::NAMED_NUM; k++) begin
        pm = (cnt_i < heu_pkg::pat_len(2'(k))) &&
             (byte_i == heu_pkg::pat_byte(2'(k), cnt_i));
        for (int i = 1; i < heu_pkg::HOLD_DEPTH; i++) begin
          if (3'(i) < cnt_i && held_i[i] != heu_pkg::pat_byte(2'(k), 3'(i))) begin
            pm = 1'b0;
          end
        end
        if (pm) begin
          if (cnt_i + 3'd1 == heu_pkg::pat_len(2'(k))) begin
            complete = 1'b1;
            val      = heu_pkg::pat_val(2'(k));
          end else begin
            partial = 1'b1;
          end
        end
      end
      if (cnt_i == 3'd1 && byte_i == heu_pkg::CHAR_HASH) begin
        partial    = 1'b1;
        to_numeric = 1'b1;
      end
    end else if (phase_i == heu_pkg::PH_NUMERIC) begin
      if (is_digit && cnt_i < 3'(heu_pkg::HOLD_DEPTH)) begin
        partial = 1'b1;
      end else if (byte_i == heu_pkg::CHAR_SEMI && cnt_i >= 3'd3) begin
        complete = 1'b1;
        val      = code_i[7:0];
      end
    end
  end

  always_comb begin
    dec_o         = '0;
    dec_o.dec_val = val;
    dec_o.wr_idx  = cnt_i;
    dec_o.cnt_d   = cnt_i;
    dec_o.phase_d = phase_i;
    dec_o.code_d  = code_i;
    if (cnt_i == 3'd0) begin
      if (last_i || !is_amp) begin
        dec_o.out_cnt = 3'd1;
      end else begin
        dec_o.wr_en   = 1'b1;
        dec_o.wr_idx  = 3'd0;
        dec_o.cnt_d   = 3'd1;
        dec_o.phase_d = heu_pkg::PH_NAMED;
        dec_o.code_d  = 10'd0;
      end
    end else if (complete) begin
      dec_o.dec_en  = 1'b1;
      dec_o.out_cnt = 3'd1;
      dec_o.cnt_d   = 3'd0;
      dec_o.phase_d = heu_pkg::PH_IDLE;
      dec_o.code_d  = 10'd0;
    end else if (partial && !last_i) begin
      dec_o.wr_en = 1'b1;
      dec_o.cnt_d = cnt_i + 3'd1;
      if (to_numeric) begin
        dec_o.phase_d = heu_pkg::PH_NUMERIC;
        dec_o.code_d  = 10'd0;
      end else if (phase_i == heu_pkg::PH_NUMERIC) begin
        // code is at most 99 here, times ten plus a digit fits
        dec_o.code_d = {code_i[6:0], 3'b000} + {code_i[8:0], 1'b0} + {6'd0, digit};
      end
    end else if (!partial && is_amp && !last_i) begin
      // flush held bytes, new escape starts
      dec_o.out_cnt = cnt_i;
      dec_o.wr_en   = 1'b1;
      dec_o.wr_idx  = 3'd0;
      dec_o.cnt_d   = 3'd1;
      dec_o.phase_d = heu_pkg::PH_NAMED;
      dec_o.code_d  = 10'd0;
    end else begin
      // held bytes then the new byte, literally
      dec_o.out_cnt = cnt_i + 3'd1;
      dec_o.cnt_d   = 3'd0;
      dec_o.phase_d = heu_pkg::PH_IDLE;
      dec_o.code_d  = 10'd0;
    end
  end

endmodule

/* rtl/core/heu_outbuf.sv */
module heu_outbuf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  logic [5:0][7:0] load_bytes_i,
  input  logic [2:0]      load_cnt_i,
  input  logic            load_last_i,
  output logic            free_o,
  output logic            valid_o,
  input  logic            stall_i,
  output logic [7:0]      byte_o,
  output logic            run_end_o,
  output logic            stream_end_o
);

  logic [5:0][7:0] buf_q, buf_d;
  logic [2:0]      rem_q, rem_d;
  logic            last_q, last_d;
  logic            pop;

  assign valid_o      = (rem_q != 3'd0);
  assign pop          = valid_o && !stall_i;
  assign free_o       = (rem_q == 3'd0) || (rem_q == 3'd1 && !stall_i);
  assign byte_o       = buf_q[0];
  assign run_end_o    = (rem_q == 3'd1);
  assign stream_end_o = (rem_q == 3'd1) && last_q;

  always_comb begin
    buf_d  = buf_q;
    rem_d  = rem_q;
    last_d = last_q;
    if (load_i) begin
      buf_d  = load_bytes_i;
      rem_d  = load_cnt_i;
      last_d = load_last_i;
    end else if (pop) begin
      for (int k = 0; k < heu_pkg::OUT_DEPTH - 1; k++) begin
        buf_d[k] = buf_q[k+1];
      end
      rem_d = rem_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= 3'd0;
      last_q <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

/* rtl/core/html_entity_unescape_core.sv */
// latency: first result of a request is valid the cycle after the request is taken
// throughput: one request per cycle while each gives at most one result and
// out_stall_i is low; a request with more results holds the input while they drain
// reset: asynchronous active low, returns to idle with nothing held and no result
// pending; held byte storage is not cleared
module html_entity_unescape_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       stream_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_end_o,
  output logic       stream_end_o
);

  // match state: phase, number of held bytes, value of pending digits
  heu_pkg::heu_phase_e phase_q;
  logic [2:0]          cnt_q;
  logic [9:0]          code_q;
  // bytes held back while an escape may still complete, oldest first
  logic [4:0][7:0]     held_q;

  heu_pkg::heu_dec_t   dec;
  logic                accept;
  logic                ob_free;
  logic [5:0][7:0]     load_bytes;

  // a request is taken whenever the result shifter can take its results
  assign in_stall_o = !ob_free;
  assign accept     = in_valid_i && !in_stall_o;

  heu_decode u_decode (
    .byte_i  (in_byte_i),
    .last_i  (stream_last_i),
    .phase_i (phase_q),
    .cnt_i   (cnt_q),
    .code_i  (code_q),
    .held_i  (held_q),
    .dec_o   (dec)
  );

  // result list is the held bytes followed by the new byte, or just the
  // decoded character when an escape completes
  always_comb begin
    for (int k = 0; k < heu_pkg::HOLD_DEPTH; k++) begin
      load_bytes[k] = (3'(k) < cnt_q) ? held_q[k] : in_byte_i;
    end
    load_bytes[heu_pkg::OUT_DEPTH-1] = in_byte_i;
    if (dec.dec_en) begin
      load_bytes[0] = dec.dec_val;
    end
  end

  heu_outbuf u_outbuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept && dec.out_cnt != 3'd0),
    .load_bytes_i (load_bytes),
    .load_cnt_i   (dec.out_cnt),
    .load_last_i  (stream_last_i),
    .free_o       (ob_free),
    .valid_o      (out_valid_o),
    .stall_i      (out_stall_i),
    .byte_o       (out_byte_o),
    .run_end_o    (run_end_o),
    .stream_end_o (stream_end_o)
  );

  // match state advances once per taken request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= heu_pkg::PH_IDLE;
      cnt_q   <= 3'd0;
      code_q  <= 10'd0;
    end else if (accept) begin
      phase_q <= dec.phase_d;
      cnt_q   <= dec.cnt_d;
      code_q  <= dec.code_d;
    end
  end

  // hold storage, only entries below the held count are ever read
  always_ff @(posedge clk_i) begin
    if (accept && dec.wr_en) begin
      held_q[dec.wr_idx] <= in_byte_i;
    end
  end

endmodule
